// File: rtl/twvs_pkg.sv
// Shared types and constants of the time-window value sum block.
package twvs_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 32;
    localparam int TOTAL_W  = 38;
    localparam int WIN_W    = 32;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [WIN_W-1:0] WIN_RESET = 32'd1000;

    // Register index, taken from the word address bit
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    // One held entry
    typedef struct packed {
        logic [TIME_W-1:0] ts;
        logic [VAL_W-1:0]  val;
    } t_entry;

    // Operation applied to the whole row of cells
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_INSERT
    } t_cell_op;

    // Control broadcast to every cell
    typedef struct packed {
        t_cell_op          op;
        logic [TIME_W-1:0] ts_new;
        logic [VAL_W-1:0]  val_new;
    } t_cell_ctl;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PURGE,
        ST_INSERT,
        ST_REPORT
    } t_state;

endpackage

// File: rtl/twvs_if.sv
// Valid/ready channel interfaces for samples and window reports.
interface twvs_in_if;
    logic                           valid;
    logic                           ready;
    logic [twvs_pkg::TIME_W-1:0]    sample_time;
    logic [twvs_pkg::VAL_W-1:0]     sample_value;

    modport source (output valid, output sample_time, output sample_value, input ready);
    modport sink   (input valid, input sample_time, input sample_value, output ready);
endinterface

interface twvs_out_if;
    logic                           valid;
    logic                           ready;
    logic [twvs_pkg::TOTAL_W-1:0]   window_total;
    logic [twvs_pkg::CNT_W-1:0]     entry_count;
    logic [twvs_pkg::TIME_W-1:0]    time_span;
    logic                           window_empty;
    logic                           store_overflow;

    modport source (output valid, output window_total, output entry_count,
                    output time_span, output window_empty, output store_overflow,
                    input ready);
    modport sink   (input valid, input window_total, input entry_count,
                    input time_span, input window_empty, input store_overflow,
                    output ready);
endinterface

// File: rtl/twvs_cell.sv
// One slot of the sorted store: holds an entry and trades it with its neighbors.
module twvs_cell (
    input  logic                 i_clk,
    input  twvs_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_occ,
    input  logic                 i_at_end,
    input  logic                 i_left_gt,
    input  twvs_pkg::t_entry     i_left,
    input  twvs_pkg::t_entry     i_right,
    output twvs_pkg::t_entry     o_entry,
    output logic                 o_gt
);

    twvs_pkg::t_entry r_entry;
    twvs_pkg::t_entry n_entry;

    // Held entry is newer than the incoming timestamp
    assign o_gt    = i_occ && (r_entry.ts > i_ctl.ts_new);
    assign o_entry = r_entry;

    // Shift left on purge; on insert, entries above the slot move right
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            twvs_pkg::OP_SHIFT: begin
                n_entry = i_right;
            end
            twvs_pkg::OP_INSERT: begin
                if (i_left_gt) begin
                    n_entry = i_left;
                end else if (o_gt || i_at_end) begin
                    n_entry.ts  = i_ctl.ts_new;
                    n_entry.val = i_ctl.val_new;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: rtl/time_window_value_sum.sv
// Time-window value sum: a sorted row of entry cells with a purge/insert sequencer.
//
// After a sample is accepted, the sequencer first purges the entries that expire on
// its arrival, up to 64 of them: the oldest entry sits in the first cell, and the
// whole row shifts toward it by one slot per cycle while its value is subtracted.
// The purge ends when the oldest remaining entry is found to be live. Then comes
// the sorted insert, in which every cell decides in parallel whether to keep, take
// its left neighbor or take the new entry. Last the report is formed, and then
// the sequencer returns to idle. A report waits in the output register until taken.
// The next sample is accepted as soon as the sequencer is back in idle, and it
// stalls only in its report state while the previous report is still waiting.
// Entries with equal timestamps are all kept, the newest last. When the store is
// full after the purge the sample is dropped and store_overflow is set.
// window_length is written through the APB port at byte address 0 and should only
// be changed while no sample is in flight.
module time_window_value_sum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [twvs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [twvs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [twvs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    twvs_in_if.sink                           i_sample,
    twvs_out_if.source                        o_result
);

    localparam int CAP   = twvs_pkg::CAPACITY;
    localparam int CNT_W = twvs_pkg::CNT_W;

    // Configuration register
    logic [twvs_pkg::WIN_W-1:0] r_win_len;
    logic                       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == twvs_pkg::REG_WINDOW_LENGTH) ? r_win_len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= twvs_pkg::WIN_RESET;
        end else if (w_cfg_wr && (paddr[2] == twvs_pkg::REG_WINDOW_LENGTH)) begin
            r_win_len <= pwdata;
        end
    end

    // Sequencer and datapath state
    twvs_pkg::t_state            r_state;
    twvs_pkg::t_state            n_state;
    logic [twvs_pkg::TIME_W-1:0] r_ts;
    logic [twvs_pkg::VAL_W-1:0]  r_val;
    logic [CNT_W-1:0]            r_count;
    logic [twvs_pkg::TOTAL_W-1:0] r_total;
    logic                        r_ovf;

    // Output register
    logic                         r_out_valid;
    logic [twvs_pkg::TOTAL_W-1:0] r_out_total;
    logic [CNT_W-1:0]             r_out_count;
    logic [twvs_pkg::TIME_W-1:0]  r_out_span;
    logic                         r_out_empty;
    logic                         r_out_ovf;

    // Cell row
    twvs_pkg::t_cell_ctl w_ctl;
    twvs_pkg::t_entry    w_ent [CAP];
    logic [CAP-1:0]      w_gt;
    logic [CAP-1:0]      w_occ;
    logic [CAP-1:0]      w_at_end;

    // Control strobes
    logic w_in_ready;
    logic w_expire;
    logic w_full;
    logic w_out_free;
    logic w_do_shift;
    logic w_do_insert;
    logic w_load_out;

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++) begin : g_cell
            twvs_pkg::t_entry w_left;
            twvs_pkg::t_entry w_right;
            logic             w_left_gt;

            assign w_occ[gi]    = r_count > CNT_W'(gi);
            assign w_at_end[gi] = r_count == CNT_W'(gi);

            if (gi == 0) begin : g_first
                assign w_left    = '0;
                assign w_left_gt = 1'b0;
            end else begin : g_mid
                assign w_left    = w_ent[gi-1];
                assign w_left_gt = w_gt[gi-1];
            end

            if (gi == CAP - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_ent[gi+1];
            end

            twvs_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_occ     (w_occ[gi]),
                .i_at_end  (w_at_end[gi]),
                .i_left_gt (w_left_gt),
                .i_left    (w_left),
                .i_right   (w_right),
                .o_entry   (w_ent[gi]),
                .o_gt      (w_gt[gi])
            );
        end
    endgenerate

    // Oldest entry expires when its time plus the window is below the new time
    assign w_expire = w_occ[0] &&
        (({1'b0, w_ent[0].ts} + {1'b0, r_win_len}) < {1'b0, r_ts});
    assign w_full     = r_count == CNT_W'(CAP);
    assign w_out_free = !r_out_valid || o_result.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            twvs_pkg::ST_IDLE:   if (i_sample.valid) n_state = twvs_pkg::ST_PURGE;
            twvs_pkg::ST_PURGE:  if (!w_expire) n_state = twvs_pkg::ST_INSERT;
            twvs_pkg::ST_INSERT: n_state = twvs_pkg::ST_REPORT;
            twvs_pkg::ST_REPORT: if (w_out_free) n_state = twvs_pkg::ST_IDLE;
            default:             n_state = twvs_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_do_shift  = 1'b0;
        w_do_insert = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            twvs_pkg::ST_IDLE:   w_in_ready  = 1'b1;
            twvs_pkg::ST_PURGE:  w_do_shift  = w_expire;
            twvs_pkg::ST_INSERT: w_do_insert = !w_full;
            twvs_pkg::ST_REPORT: w_load_out  = w_out_free;
            default:             w_in_ready  = 1'b0;
        endcase
    end

    assign i_sample.ready = w_in_ready;

    always_comb begin
        w_ctl.ts_new  = r_ts;
        w_ctl.val_new = r_val;
        if (w_do_shift) begin
            w_ctl.op = twvs_pkg::OP_SHIFT;
        end else if (w_do_insert) begin
            w_ctl.op = twvs_pkg::OP_INSERT;
        end else begin
            w_ctl.op = twvs_pkg::OP_HOLD;
        end
    end

    // Newest held timestamp, tracked on insert; the purge only drops the oldest end
    logic [twvs_pkg::TIME_W-1:0] r_newest;
    logic [twvs_pkg::TIME_W-1:0] w_span;

    always_ff @(posedge i_clk) begin
        if (w_do_insert && ((r_count == '0) || (r_ts > r_newest))) begin
            r_newest <= r_ts;
        end
    end

    assign w_span = (r_count >= CNT_W'(2)) ? (r_newest - w_ent[0].ts) : '0;

    // Sequencer, count and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twvs_pkg::ST_IDLE;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (w_do_shift) begin
                r_count <= r_count - CNT_W'(1);
                r_total <= r_total - {{(twvs_pkg::TOTAL_W - twvs_pkg::VAL_W){1'b0}},
                                      w_ent[0].val};
            end else if (w_do_insert) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= r_total + {{(twvs_pkg::TOTAL_W - twvs_pkg::VAL_W){1'b0}},
                                      r_val};
            end
        end
    end

    // Sample latch and overflow flag
    always_ff @(posedge i_clk) begin
        if (i_sample.valid && w_in_ready) begin
            r_ts  <= i_sample.sample_time;
            r_val <= i_sample.sample_value;
        end
        if (r_state == twvs_pkg::ST_INSERT) begin
            r_ovf <= w_full;
        end
    end

    // Report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_total <= r_total;
            r_out_count <= r_count;
            r_out_span  <= w_span;
            r_out_empty <= (r_count == '0);
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.window_total   = r_out_total;
    assign o_result.entry_count    = r_out_count;
    assign o_result.time_span      = r_out_span;
    assign o_result.window_empty   = r_out_empty;
    assign o_result.store_overflow = r_out_ovf;

endmodule

// File: sim/tb_time_window_value_sum.sv
// Self-checking testbench of the time-window value sum block.
module tb_time_window_value_sum;
    import twvs_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;  // cycles with no handshake at all
    localparam int unsigned TAIL_CYCLES = 80;    // a full purge of the store plus margin
    localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_LENGTH, 2'b00};

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [CNT_W-1:0]   count;
        logic [TIME_W-1:0]  span;
        logic               empty;
        logic               overflow;
    } window_report_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WINDOW
    } row_kind_e;

    // arg_a is the timestamp of a sample row or the new window of a window row
    typedef struct {
        row_kind_e      kind;
        logic [31:0]    arg_a;
        logic [31:0]    arg_b;
        bit             typed;
        window_report_t want;
    } stim_row_t;

    typedef struct {
        logic [WIN_W-1:0] win;
        bit               rand_win;
        int unsigned      items;
        int unsigned      step;
    } burst_t;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    twvs_in_if  smp ();
    twvs_out_if res ();

    time_window_value_sum uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_sample (smp),
        .o_result (res)
    );

    // Directed stimulus; expected reports typed only where obvious
    stim_row_t directed_rows [0:18] = '{
        '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{38'h0, 7'd1, 32'd0, 1'b0, 1'b0}},
        '{ROW_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{38'hFFFF_FFFF, 7'd2, 32'd0, 1'b0, 1'b0}},
        '{ROW_SAMPLE, 32'd1000, 32'h0000_0001, 1'b1,
          '{38'h1_0000_0000, 7'd3, 32'd1000, 1'b0, 1'b0}},
        '{ROW_SAMPLE, 32'd1001, 32'h0000_0005, 1'b1,
          '{38'd6, 7'd2, 32'd1, 1'b0, 1'b0}},
        '{ROW_SAMPLE, 32'd500, 32'h0000_0003, 1'b0, '0},
        '{ROW_SAMPLE, 32'd1001, 32'h8000_0000, 1'b0, '0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{38'hFFFF_FFFF, 7'd1, 32'd0, 1'b0, 1'b0}},
        '{ROW_SAMPLE, 32'hFFFF_FC17, 32'h0000_0007, 1'b0, '0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{ROW_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
        '{ROW_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{ROW_WINDOW, 32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0002, 1'b0, '0},
        '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0001, 1'b0, '0},
        '{ROW_WINDOW, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
        '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{ROW_WINDOW, 32'h0000_0001, 32'h0, 1'b0, '0},
        '{ROW_SAMPLE, 32'h0000_0002, 32'h0000_0009, 1'b0, '0},
        '{ROW_SAMPLE, 32'h0000_0003, 32'h7FFF_FFFF, 1'b0, '0}
    };

    // Random bursts: window setting, length, largest forward time step
    burst_t bursts [0:6] = '{
        '{32'd1000,      1'b0, 110, 400},
        '{32'd0,         1'b0, 40,  2},
        '{32'd1,         1'b0, 40,  3},
        '{32'd0,         1'b1, 40,  1 << 22},
        '{32'hFFFF_FFFF, 1'b0, 80,  5000},
        '{32'd100,       1'b0, 60,  3},
        '{32'd0,         1'b0, 20,  1}
    };

    // Window model
    logic [TIME_W-1:0]  held_stamp [CAPACITY];
    logic [VAL_W-1:0]   held_value [CAPACITY];
    int unsigned        held_n;
    logic [TOTAL_W-1:0] held_sum;
    logic [WIN_W-1:0]   model_window;

    window_report_t pending_reports [$];

    int unsigned mismatch_count;
    int unsigned reports_checked;
    int unsigned samples_sent;
    int unsigned overflow_seen;
    int unsigned quiet_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;
    logic [31:0] cur_stamp;

    // Purge, sorted insert and report, as the block does for one sample
    function automatic window_report_t advance_window(input logic [TIME_W-1:0] stamp,
                                                      input logic [VAL_W-1:0] value);
        window_report_t rep;
        int unsigned    gone;
        int unsigned    pos;
        int             i;
        gone = 0;
        while (gone < held_n &&
               ({1'b0, held_stamp[gone]} + {1'b0, model_window}) < {1'b0, stamp}) begin
            held_sum = held_sum - TOTAL_W'(held_value[gone]);
            gone++;
        end
        for (i = 0; i < int'(held_n - gone); i++) begin
            held_stamp[i] = held_stamp[i + gone];
            held_value[i] = held_value[i + gone];
        end
        held_n = held_n - gone;
        rep.overflow = (held_n >= CAPACITY);
        if (!rep.overflow) begin
            pos = held_n;
            while (pos > 0 && held_stamp[pos - 1] > stamp) pos--;
            for (i = int'(held_n); i > int'(pos); i--) begin
                held_stamp[i] = held_stamp[i - 1];
                held_value[i] = held_value[i - 1];
            end
            held_stamp[pos] = stamp;
            held_value[pos] = value;
            held_n++;
            held_sum = held_sum + TOTAL_W'(value);
        end
        rep.total = held_sum;
        rep.count = CNT_W'(held_n);
        rep.span  = (held_n >= 2) ? held_stamp[held_n - 1] - held_stamp[0] : '0;
        rep.empty = (held_n == 0);
        return rep;
    endfunction

    // Next random timestamp: mostly forward, some equal, older or far jumps
    function automatic logic [31:0] pick_stamp(input int unsigned step);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            cur_stamp = $urandom();
            return cur_stamp;
        end
        if (r < 12) return cur_stamp - $urandom_range(1, step + 2);
        if (r < 20) return cur_stamp;
        cur_stamp = cur_stamp + $urandom_range(0, step);
        return cur_stamp;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("report %0d: %s expected 0x%0h, got 0x%0h",
                         reports_checked, name, want, got);
        end
    endtask

    // One sample request; returns at the falling edge after acceptance
    task automatic drive_sample(input logic [31:0] stamp, input logic [31:0] value,
                                input bit typed, input window_report_t want);
        int unsigned    gap;
        window_report_t rep;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 29) == 0) tx_idle_on = !tx_idle_on;
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp.valid        <= 1'b1;
        smp.sample_time  <= stamp;
        smp.sample_value <= value;
        do @(posedge i_clk); while (!smp.ready);
        rep = advance_window(stamp, value);
        pending_reports.push_back(typed ? want : rep);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every report has come back
    task automatic drain_reports();
        smp.valid <= 1'b0;
        do @(negedge i_clk); while (pending_reports.size() != 0);
    endtask

    // APB write of the window, then read it back
    task automatic set_window(input logic [WIN_W-1:0] win);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= win;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model_window = win;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== win) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("window readback: expected 0x%0h, got 0x%0h", win, got);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls before each report
    initial begin : result_sink
        int unsigned gap;
        res.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, 10) : 0;
            if ($urandom_range(0, 29) == 0) rx_idle_on = !rx_idle_on;
            if (gap > 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
            @(negedge i_clk);
        end
    end

    // Report checker
    always @(posedge i_clk) begin
        window_report_t want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("report with no sample outstanding: total 0x%0h count %0d",
                             res.window_total, res.entry_count);
            end else begin
                want = pending_reports.pop_front();
                check_field("window_total",   want.total,    res.window_total);
                check_field("entry_count",    want.count,    res.entry_count);
                check_field("time_span",      want.span,     res.time_span);
                check_field("window_empty",   want.empty,    res.window_empty);
                check_field("store_overflow", want.overflow, res.store_overflow);
                if (want.overflow) overflow_seen++;
            end
            reports_checked++;
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (res.valid && res.ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d reports outstanding",
                     quiet_cycles, pending_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        int unsigned leftover;
        logic [WIN_W-1:0] win;
        logic [31:0] value;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        smp.valid        = 1'b0;
        smp.sample_time  = '0;
        smp.sample_value = '0;
        held_n           = 0;
        held_sum         = '0;
        model_window     = WIN_RESET;
        mismatch_count   = 0;
        reports_checked  = 0;
        samples_sent     = 0;
        overflow_seen    = 0;
        quiet_cycles     = 0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows, starting from the reset window
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_WINDOW) begin
                drain_reports();
                set_window(directed_rows[k].arg_a);
            end else begin
                drive_sample(directed_rows[k].arg_a, directed_rows[k].arg_b,
                             directed_rows[k].typed, directed_rows[k].want);
            end
        end
        cur_stamp = 32'd3;

        // Random bursts, one window setting each
        foreach (bursts[b]) begin
            drain_reports();
            win = bursts[b].rand_win ? $urandom_range(1, 32'h00FF_FFFF) : bursts[b].win;
            set_window(win);
            tx_idle_on = (b != 2);
            rx_idle_on = (b != 2);
            for (int n = 0; n < int'(bursts[b].items); n++) begin
                // occasionally hold off until the block has caught up
                if ($urandom_range(0, 39) == 0) drain_reports();
                value = ($urandom_range(0, 9) == 0) ? {32{$urandom_range(0, 1) == 1}}
                                                    : $urandom();
                drive_sample(pick_stamp(bursts[b].step), value, 1'b0, '0);
            end
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        leftover = pending_reports.size();
        $display("Checked %0d reports for %0d samples, %0d of them store overflows.",
                 reports_checked, samples_sent, overflow_seen);
        $display("Windows from 0 to 0xFFFFFFFF, %0d mismatches, %0d reports missing.",
                 mismatch_count, leftover);
        if (mismatch_count == 0 && leftover == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
